FILE: rtl/core/catmull_rom_point_evaluator_unit_assert.svh
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_POINT_EVALUATOR_UNIT_ASSERT_SVH
`define CATMULL_ROM_POINT_EVALUATOR_UNIT_ASSERT_SVH

// Checks a consequent in the same cycle as its antecedent.
`define CRPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define CRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/crpe_pkg.sv
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator package
// Widths, types, register indexes and reset values shared by the block.
// ----------------------------------------------------------------------------
package crpe_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int T_FRAC_BITS = 16;

  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_AW     = REG_IDX_W + 2;
  localparam int CFG_DW     = 32;

  localparam int UU_W   = 2 * T_FRAC_BITS;
  localparam int Q_W    = T_FRAC_BITS + 3;
  localparam int PROD_W = COORD_WIDTH + Q_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SHIFT  = T_FRAC_BITS + 1;

  localparam int NUM_STG = 7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [T_FRAC_BITS-1:0] frac_t;
  typedef logic signed [Q_W-1:0]         q_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [PAIR_W-1:0]      pair_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic        [REG_IDX_W-1:0]   reg_idx_t;

  typedef struct packed {
    logic signed [Q_W-1:0] q0;
    logic signed [Q_W-1:0] q1;
    logic signed [Q_W-1:0] q2;
    logic signed [Q_W-1:0] q3;
  } wgt_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] p0;
    logic signed [COORD_WIDTH-1:0] p1;
    logic signed [COORD_WIDTH-1:0] p2;
    logic signed [COORD_WIDTH-1:0] p3;
  } axis_pts_t;

  typedef struct packed {
    logic [NUM_STG-1:0] load;
  } pipe_ctrl_t;

  localparam reg_idx_t REG_P0_X = reg_idx_t'(0);
  localparam reg_idx_t REG_P0_Y = reg_idx_t'(1);
  localparam reg_idx_t REG_P1_X = reg_idx_t'(2);
  localparam reg_idx_t REG_P1_Y = reg_idx_t'(3);
  localparam reg_idx_t REG_P2_X = reg_idx_t'(4);
  localparam reg_idx_t REG_P2_Y = reg_idx_t'(5);
  localparam reg_idx_t REG_P3_X = reg_idx_t'(6);
  localparam reg_idx_t REG_P3_Y = reg_idx_t'(7);

  localparam coord_t RESET_PTS [NUM_REGS] = '{
    coord_t'(10),  coord_t'(30),  coord_t'(140), coord_t'(70),
    coord_t'(140), coord_t'(110), coord_t'(40),  coord_t'(50)
  };

  localparam q_t     Q_TWO     = q_t'(64'd1 << SHIFT);
  localparam sum_t   TRUNC_BIAS = sum_t'((64'd1 << SHIFT) - 64'd1);
  localparam coord_t COORD_MAX = coord_t'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam coord_t COORD_MIN = coord_t'(64'd1 << (COORD_WIDTH - 1));

endpackage

FILE: rtl/core/crpe_in_if.sv
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator input channel
// Valid/ready channel carrying the curve parameter of one item.
// ----------------------------------------------------------------------------
interface crpe_in_if;
  logic              valid;
  logic              ready;
  crpe_pkg::frac_t   t_frac;

  modport source (output valid, output t_frac, input ready);
  modport sink   (input valid, input t_frac, output ready);
endinterface

FILE: rtl/core/crpe_out_if.sv
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator result channel
// Valid/ready channel carrying one curve point.
// ----------------------------------------------------------------------------
interface crpe_out_if;
  logic              valid;
  logic              ready;
  crpe_pkg::coord_t  curve_x;
  crpe_pkg::coord_t  curve_y;

  modport source (output valid, output curve_x, output curve_y, input ready);
  modport sink   (input valid, input curve_x, input curve_y, output ready);
endinterface

FILE: rtl/core/crpe_weights.sv
// ----------------------------------------------------------------------------
// Catmull-Rom basis weights
// Three stages: t squared, t cubed, then the four weights scaled by two.
// ----------------------------------------------------------------------------
module crpe_weights (
  input  logic                 clk,
  input  crpe_pkg::pipe_ctrl_t ctrl,
  input  crpe_pkg::frac_t      t_frac,
  output crpe_pkg::wgt_t       wgt
);

  crpe_pkg::frac_t u1_r, tt1_r;
  crpe_pkg::frac_t u2_r, tt2_r, ttt2_r;
  crpe_pkg::wgt_t  wgt_r;

  logic [crpe_pkg::UU_W-1:0] uu;
  logic [crpe_pkg::UU_W-1:0] tuu;
  crpe_pkg::frac_t           tt_nxt;
  crpe_pkg::frac_t           ttt_nxt;
  crpe_pkg::q_t              u_s, tt_s, ttt_s;
  crpe_pkg::wgt_t            wgt_nxt;

  always_comb begin
    uu      = crpe_pkg::UU_W'(t_frac) * crpe_pkg::UU_W'(t_frac);
    tt_nxt  = uu[crpe_pkg::UU_W-1:crpe_pkg::T_FRAC_BITS];
    tuu     = crpe_pkg::UU_W'(tt1_r) * crpe_pkg::UU_W'(u1_r);
    ttt_nxt = tuu[crpe_pkg::UU_W-1:crpe_pkg::T_FRAC_BITS];
  end

  always_comb begin
    u_s   = crpe_pkg::q_t'(u2_r);
    tt_s  = crpe_pkg::q_t'(tt2_r);
    ttt_s = crpe_pkg::q_t'(ttt2_r);
    wgt_nxt.q0 = (tt_s <<< 1) - ttt_s - u_s;
    wgt_nxt.q1 = (ttt_s <<< 1) + ttt_s - (tt_s <<< 2) - tt_s + crpe_pkg::Q_TWO;
    wgt_nxt.q2 = u_s + (tt_s <<< 2) - (ttt_s <<< 1) - ttt_s;
    wgt_nxt.q3 = ttt_s - tt_s;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      u1_r  <= t_frac;
      tt1_r <= tt_nxt;
    end
    if (ctrl.load[1]) begin
      u2_r   <= u1_r;
      tt2_r  <= tt1_r;
      ttt2_r <= ttt_nxt;
    end
    if (ctrl.load[2]) begin
      wgt_r <= wgt_nxt;
    end
  end

  assign wgt = wgt_r;

endmodule

FILE: rtl/core/crpe_blend.sv
// ----------------------------------------------------------------------------
// Catmull-Rom axis blend
// Weights four control coordinates, sums them, then truncates and saturates.
// ----------------------------------------------------------------------------
module crpe_blend (
  input  logic                 clk,
  input  crpe_pkg::pipe_ctrl_t ctrl,
  input  crpe_pkg::wgt_t       wgt,
  input  crpe_pkg::axis_pts_t  pts,
  output crpe_pkg::coord_t     coord
);

  crpe_pkg::prod_t  prod0_r, prod1_r, prod2_r, prod3_r;
  crpe_pkg::pair_t  pair0_r, pair1_r;
  crpe_pkg::sum_t   total_r;
  crpe_pkg::coord_t coord_r;

  crpe_pkg::sum_t   adj;
  crpe_pkg::sum_t   quo;
  crpe_pkg::coord_t coord_nxt;

  always_comb begin
    adj = total_r + (total_r[crpe_pkg::SUM_W-1] ? crpe_pkg::TRUNC_BIAS : '0);
    quo = adj >>> crpe_pkg::SHIFT;
    if (quo > crpe_pkg::sum_t'(crpe_pkg::COORD_MAX)) begin
      coord_nxt = crpe_pkg::COORD_MAX;
    end else if (quo < crpe_pkg::sum_t'(crpe_pkg::COORD_MIN)) begin
      coord_nxt = crpe_pkg::COORD_MIN;
    end else begin
      coord_nxt = crpe_pkg::coord_t'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      prod0_r <= crpe_pkg::prod_t'(pts.p0) * crpe_pkg::prod_t'(wgt.q0);
      prod1_r <= crpe_pkg::prod_t'(pts.p1) * crpe_pkg::prod_t'(wgt.q1);
      prod2_r <= crpe_pkg::prod_t'(pts.p2) * crpe_pkg::prod_t'(wgt.q2);
      prod3_r <= crpe_pkg::prod_t'(pts.p3) * crpe_pkg::prod_t'(wgt.q3);
    end
    if (ctrl.load[4]) begin
      pair0_r <= crpe_pkg::pair_t'(prod0_r) + crpe_pkg::pair_t'(prod1_r);
      pair1_r <= crpe_pkg::pair_t'(prod2_r) + crpe_pkg::pair_t'(prod3_r);
    end
    if (ctrl.load[5]) begin
      total_r <= crpe_pkg::sum_t'(pair0_r) + crpe_pkg::sum_t'(pair1_r);
    end
    if (ctrl.load[6]) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

FILE: rtl/core/catmull_rom_point_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator
// Evaluates one 2-D uniform Catmull-Rom segment at a Q0.16 parameter t.
// ----------------------------------------------------------------------------
// The block takes one item per clock while its result is not stalled and
// returns the curve point after seven register stages, one each for t
// squared, t cubed, the basis weights, the coordinate products, the pair
// sums, the full sum and the final truncation and saturation. Every stage
// holds its item under backpressure and pulls the next one in as soon as it
// empties, so a stalled result only blocks input once all seven stages are
// full. The four control points are written over the APB port at byte
// address 4*i and may only change while no item is in flight.
`include "catmull_rom_point_evaluator_unit_assert.svh"

module catmull_rom_point_evaluator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  crpe_in_if.sink                       in_ch,
  crpe_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crpe_pkg::CFG_AW-1:0]   paddr,
  input  logic [crpe_pkg::CFG_DW-1:0]   pwdata,
  output logic [crpe_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  crpe_pkg::coord_t pt_r [crpe_pkg::NUM_REGS];

  logic [crpe_pkg::NUM_STG-1:0] valid_r;
  logic [crpe_pkg::NUM_STG-1:0] valid_nxt;
  logic [crpe_pkg::NUM_STG:0]   stg_rdy;
  logic [crpe_pkg::NUM_STG-1:0] prev_valid;
  crpe_pkg::pipe_ctrl_t         ctrl;

  crpe_pkg::reg_idx_t  reg_idx;
  logic                cfg_wr;
  crpe_pkg::wgt_t      wgt;
  crpe_pkg::axis_pts_t pts_x, pts_y;
  crpe_pkg::coord_t    coord_x, coord_y;
  logic                in_acc, out_acc;

  assign reg_idx = paddr[crpe_pkg::CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = {{(crpe_pkg::CFG_DW - crpe_pkg::COORD_WIDTH){1'b0}}, pt_r[reg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < crpe_pkg::NUM_REGS; i++) begin
        pt_r[i] <= crpe_pkg::RESET_PTS[i];
      end
    end else if (cfg_wr) begin
      pt_r[reg_idx] <= crpe_pkg::coord_t'(pwdata[crpe_pkg::COORD_WIDTH-1:0]);
    end
  end

  always_comb begin
    prev_valid = {valid_r[crpe_pkg::NUM_STG-2:0], in_ch.valid};
    stg_rdy[crpe_pkg::NUM_STG] = out_ch.ready;
    for (int k = crpe_pkg::NUM_STG - 1; k >= 0; k--) begin
      stg_rdy[k] = !valid_r[k] || stg_rdy[k+1];
    end
    for (int k = 0; k < crpe_pkg::NUM_STG; k++) begin
      ctrl.load[k] = stg_rdy[k] && prev_valid[k];
      valid_nxt[k] = stg_rdy[k] ? prev_valid[k] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign pts_x = '{p0: pt_r[crpe_pkg::REG_P0_X], p1: pt_r[crpe_pkg::REG_P1_X],
                   p2: pt_r[crpe_pkg::REG_P2_X], p3: pt_r[crpe_pkg::REG_P3_X]};
  assign pts_y = '{p0: pt_r[crpe_pkg::REG_P0_Y], p1: pt_r[crpe_pkg::REG_P1_Y],
                   p2: pt_r[crpe_pkg::REG_P2_Y], p3: pt_r[crpe_pkg::REG_P3_Y]};

  crpe_weights u_weights (
    .clk    (clk),
    .ctrl   (ctrl),
    .t_frac (in_ch.t_frac),
    .wgt    (wgt)
  );

  crpe_blend u_blend_x (
    .clk   (clk),
    .ctrl  (ctrl),
    .wgt   (wgt),
    .pts   (pts_x),
    .coord (coord_x)
  );

  crpe_blend u_blend_y (
    .clk   (clk),
    .ctrl  (ctrl),
    .wgt   (wgt),
    .pts   (pts_y),
    .coord (coord_y)
  );

  assign in_ch.ready    = stg_rdy[0];
  assign out_ch.valid   = valid_r[crpe_pkg::NUM_STG-1];
  assign out_ch.curve_x = coord_x;
  assign out_ch.curve_y = coord_y;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  `CRPE_ASSERT_NEXT(a_item_count, 1'b1, $countones(valid_r) == $past($countones(valid_r)) + int'($past(in_acc)) - int'($past(out_acc)), "item count in pipeline does not match handshakes")
  `CRPE_ASSERT_NOW(a_ready_when_room, !(&valid_r), in_ch.ready, "input stalled while a stage is empty")
  `CRPE_ASSERT_NEXT(a_cfg_write, cfg_wr, pt_r[$past(reg_idx)] == $past(pwdata[crpe_pkg::COORD_WIDTH-1:0]), "control point write lost")

endmodule

FILE: tb/catmull_rom_point_evaluator_unit_test.sv
// ----------------------------------------------------------------------------
// Catmull-Rom point evaluator testbench
// Drives curve parameters into the evaluator with random gaps and stalls,
// predicts each curve point in fixed point from the configured control points
// and checks every result in order. Control points are loaded over the APB
// port between phases and read back.
// ----------------------------------------------------------------------------
module catmull_rom_point_evaluator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  class curve_point_board;
    typedef struct {
      crpe_pkg::frac_t  t;
      crpe_pkg::coord_t x;
      crpe_pkg::coord_t y;
    } point_t;

    crpe_pkg::coord_t pts[crpe_pkg::NUM_REGS];
    point_t           want_q[$];
    int               errors;
    int               items;
    int               points;
    int               clamps;

    function new();
      foreach (pts[i]) pts[i] = crpe_pkg::RESET_PTS[i];
    endfunction

    function crpe_pkg::coord_t blend_axis(longint w[4], int axis);
      longint acc = 0;
      longint c;
      for (int i = 0; i < 4; i++) acc += longint'(pts[2 * i + axis]) * w[i];
      c = acc / (longint'(1) << (crpe_pkg::T_FRAC_BITS + 1));
      if (c > longint'(crpe_pkg::COORD_MAX)) begin
        c = longint'(crpe_pkg::COORD_MAX);
        clamps++;
      end else if (c < longint'(crpe_pkg::COORD_MIN)) begin
        c = longint'(crpe_pkg::COORD_MIN);
        clamps++;
      end
      return crpe_pkg::coord_t'(c);
    endfunction

    function void note_t(crpe_pkg::frac_t t);
      longint u = longint'(t);
      longint s = longint'(1) << crpe_pkg::T_FRAC_BITS;
      longint tt;
      longint ttt;
      longint w[4];
      point_t p;
      tt = (u * u) >> crpe_pkg::T_FRAC_BITS;
      ttt = (tt * u) >> crpe_pkg::T_FRAC_BITS;
      w[0] = -ttt + 2 * tt - u;
      w[1] = 3 * ttt - 5 * tt + 2 * s;
      w[2] = -3 * ttt + 4 * tt + u;
      w[3] = ttt - tt;
      p.t = t;
      p.x = blend_axis(w, 0);
      p.y = blend_axis(w, 1);
      want_q.push_back(p);
      items++;
    endfunction

    function void check_point(crpe_pkg::coord_t x, crpe_pkg::coord_t y);
      point_t p;
      points++;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected curve point (%0d, %0d)", $time, x, y);
        errors++;
        return;
      end
      p = want_q.pop_front();
      if (x !== p.x) begin
        $display("%0t: curve_x for t=%h: expected %0d, actual %0d", $time, p.t, p.x, x);
        errors++;
      end
      if (y !== p.y) begin
        $display("%0t: curve_y for t=%h: expected %0d, actual %0d", $time, p.t, p.y, y);
        errors++;
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [crpe_pkg::CFG_AW-1:0] paddr;
  logic [crpe_pkg::CFG_DW-1:0] pwdata;
  logic [crpe_pkg::CFG_DW-1:0] prdata;
  logic                        pready;

  crpe_in_if  in_ch ();
  crpe_out_if out_ch ();

  curve_point_board sb = new();

  bit   gaps_en  = 1'b1;
  bit   stall_en = 1'b1;
  int   hold_left = 0;
  logic ready_next = 1'b0;
  int   cfg_sets = 0;

  catmull_rom_point_evaluator_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20_000_000);
    $display("catmull_rom_point_evaluator_unit_test: FAIL");
    $finish;
  end

  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    int pick;
    if (hold_left == 0) begin
      pick = $urandom_range(0, 99);
      if (!stall_en || pick < 50) begin
        ready_next = 1'b1;
        hold_left = $urandom_range(1, 40);
      end else if (pick < 85) begin
        ready_next = 1'b0;
        hold_left = $urandom_range(1, 3);
      end else begin
        ready_next = 1'b0;
        hold_left = $urandom_range(8, 30);
      end
    end
    hold_left--;
    out_ch.ready <= ready_next;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_t(in_ch.t_frac);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_point(out_ch.curve_x, out_ch.curve_y);
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic crpe_pkg::frac_t pick_t();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return crpe_pkg::frac_t'($urandom);
    if (r < 80) return crpe_pkg::frac_t'($urandom_range(0, 255));
    if (r < 90) return crpe_pkg::frac_t'('1) - crpe_pkg::frac_t'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return crpe_pkg::frac_t'(1);
      2: return crpe_pkg::frac_t'(1) << (crpe_pkg::T_FRAC_BITS - 1);
      default: return '1;
    endcase
  endfunction

  task automatic push_t(input crpe_pkg::frac_t t, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.t_frac <= t;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (crpe_pkg::NUM_STG + 2) @(negedge clk);
  endtask

  task automatic cfg_write(input crpe_pkg::reg_idx_t idx, input crpe_pkg::coord_t val);
    logic [crpe_pkg::CFG_DW-1:0] word;
    word = crpe_pkg::CFG_DW'($urandom);
    word[crpe_pkg::COORD_WIDTH-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.pts[idx] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_read_check(input crpe_pkg::reg_idx_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[crpe_pkg::COORD_WIDTH-1:0] !== sb.pts[idx]) begin
      $display("%0t: register %0d readback: expected %0d, actual %0d",
               $time, idx, sb.pts[idx], $signed(prdata[crpe_pkg::COORD_WIDTH-1:0]));
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_points(input crpe_pkg::coord_t p[crpe_pkg::NUM_REGS]);
    for (int i = 0; i < crpe_pkg::NUM_REGS; i++) cfg_write(crpe_pkg::reg_idx_t'(i), p[i]);
    for (int i = 0; i < crpe_pkg::NUM_REGS; i++) cfg_read_check(crpe_pkg::reg_idx_t'(i));
    cfg_sets++;
  endtask

  task automatic pick_points(output crpe_pkg::coord_t p[crpe_pkg::NUM_REGS], input int kind);
    for (int i = 0; i < crpe_pkg::NUM_REGS; i++) begin
      case (kind)
        0: p[i] = crpe_pkg::coord_t'($urandom);
        1: p[i] = crpe_pkg::coord_t'(int'($urandom_range(0, 1000)) - 500);
        2: begin
          case ($urandom_range(0, 3))
            0: p[i] = crpe_pkg::COORD_MAX;
            1: p[i] = crpe_pkg::COORD_MIN;
            2: p[i] = '0;
            default: p[i] = crpe_pkg::coord_t'($urandom);
          endcase
        end
        default: begin
          if ($urandom_range(0, 1)) begin
            p[i] = crpe_pkg::COORD_MAX - crpe_pkg::coord_t'($urandom_range(0, 200));
          end else begin
            p[i] = crpe_pkg::COORD_MIN + crpe_pkg::coord_t'($urandom_range(0, 200));
          end
        end
      endcase
    end
  endtask

  initial begin
    crpe_pkg::coord_t pset[crpe_pkg::NUM_REGS];
    crpe_pkg::frac_t  dir_t[8];
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.t_frac = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    dir_t = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF,
              16'h4000, 16'hC000, 16'h5555, 16'hAAAA};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < crpe_pkg::NUM_REGS; i++) cfg_read_check(crpe_pkg::reg_idx_t'(i));
    foreach (dir_t[i]) push_t(dir_t[i], 0);
    wait_drained();

    pset = '{crpe_pkg::COORD_MIN, crpe_pkg::COORD_MAX, crpe_pkg::COORD_MAX, crpe_pkg::COORD_MIN,
             crpe_pkg::COORD_MAX, crpe_pkg::COORD_MIN, crpe_pkg::COORD_MIN, crpe_pkg::COORD_MAX};
    load_points(pset);
    push_t(crpe_pkg::frac_t'(16'h8000), 0);
    push_t(crpe_pkg::frac_t'(16'h0001), 0);
    push_t(crpe_pkg::frac_t'(16'hFFFF), 0);
    push_t(crpe_pkg::frac_t'(16'h2000), 0);
    wait_drained();

    pset = '{crpe_pkg::COORD_MAX, crpe_pkg::COORD_MIN, crpe_pkg::COORD_MAX, crpe_pkg::COORD_MIN,
             crpe_pkg::COORD_MAX, crpe_pkg::COORD_MIN, crpe_pkg::COORD_MAX, crpe_pkg::COORD_MIN};
    load_points(pset);
    push_t(crpe_pkg::frac_t'(16'h0000), 0);
    push_t(crpe_pkg::frac_t'(16'h8000), 0);
    push_t(crpe_pkg::frac_t'(16'hFFFF), 0);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      gaps_en  = (phase % 3 != 0);
      stall_en = (phase % 4 != 0);
      pick_points(pset, phase % 4);
      load_points(pset);
      for (int n = 0; n < 235; n++) begin
        if (n == 120 && phase % 2 == 1) wait_drained();
        push_t(pick_t(), pick_gap());
      end
      wait_drained();
    end

    wait_drained();
    if (sb.pending() != 0) begin
      $display("%0t: %0d curve points never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Sent %0d parameters and checked %0d curve points under %0d control point sets.",
             sb.items, sb.points, cfg_sets);
    $display("%0d predicted coordinates were clamped to the coordinate range.", sb.clamps);
    if (sb.errors == 0) begin
      $display("catmull_rom_point_evaluator_unit_test: PASS");
    end else begin
      $display("catmull_rom_point_evaluator_unit_test: FAIL");
    end
    $finish;
  end

endmodule
